// File: design/vector_dot_norm_cosine_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for vector_dot_norm_cosine
// Same-cycle and next-cycle implication checks on the rising edge of clk.
// ---------------------------------------------------------------------------
`ifndef VECTOR_DOT_NORM_COSINE_DEFINES_SVH
`define VECTOR_DOT_NORM_COSINE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define VDNC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VDNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vdnc_pkg.sv
// ---------------------------------------------------------------------------
// vdnc_pkg
// Widths, step counts and sequencer states of the cosine similarity block.
// ---------------------------------------------------------------------------
package vdnc_pkg;

  localparam int ELEM_W     = 16;
  localparam int SUM_W      = 28;
  localparam int ACC_W      = 44;
  localparam int NORM_W     = 22;
  localparam int COS_W      = 16;
  localparam int CNT_W      = 13;
  localparam int MAX_LEN    = 4096;
  localparam int HALF_W     = ACC_W / 2;
  localparam int WIDE_W     = 2 * ACC_W;
  localparam int QUO_W      = 31;
  localparam int STEP_W     = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 2;

  localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_LEN);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ACC_W / 2 - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0] PP_LAST   = STEP_W'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AB,
    ST_AA,
    ST_BB,
    ST_BB_ADD,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_MUL_D,
    ST_MUL_P,
    ST_DIV,
    ST_SQRT_Q,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SQ_SRC_A,
    SQ_SRC_B,
    SQ_SRC_Q
  } sq_src_t;

endpackage

// File: design/vector_dot_norm_cosine.sv
// ---------------------------------------------------------------------------
// vector_dot_norm_cosine
// Streaming cosine similarity of two Q3.12 vectors with sums and norms.
// ---------------------------------------------------------------------------
// Input stream: one word per element pair, s_tdata = {elem_b, elem_a}, s_tlast
// marks the final pair of a vector. Output stream: one word per vector, taken
// on m_tvalid & m_tready.
// Each element pair passes the accept cycle in the idle state and then the
// states AB, AA, BB and BB_ADD on the shared 22x22 multiplier (a*b, a*a, b*b
// and the last accumulate). s_tready is high only in the idle state.
// On a last pair the sequencer then runs two 22-step square roots for the
// norms, two four-partial-product multiplies (dot^2 and sqa*sqb), a 31-step
// restoring division and a 22-step square root for the cosine; when a norm is
// zero it goes from the norms straight to its finish state. Pairs past 4096
// are dropped and flag overflow.
// The result sits in an output register; the next vector is accepted while
// it waits, and the block holds in its finish state only when a second
// result is ready before the first was taken.
// Reset (rst, synchronous) clears all sums, the pair count and m_tvalid.
// ---------------------------------------------------------------------------
`include "vector_dot_norm_cosine_defines.svh"

module vector_dot_norm_cosine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [vdnc_pkg::IN_DATA_W-1:0]      s_tdata,  // elem_a[15:0], elem_b[31:16]
  input  logic                                s_tlast,  // last_item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sum_a[27:0], dot_product[71:28], norm_a[93:72], norm_b[115:94],
  // cosine[131:116], element_count[144:132], zero pad[151:145]
  output logic [vdnc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [vdnc_pkg::OUT_USER_W-1:0]     m_tuser   // zero_norm[0], overflow[1]
);

  vdnc_pkg::state_t  state, state_next;
  vdnc_pkg::sq_src_t sq_src;
  logic              sq_load;
  logic              out_load;
  logic              accept;

  logic [vdnc_pkg::STEP_W-1:0] step;

  // element word
  logic signed [vdnc_pkg::ELEM_W-1:0] a_reg, b_reg;
  logic                               last_reg;
  logic signed [vdnc_pkg::ELEM_W:0]   a_abs, b_abs;
  logic [vdnc_pkg::HALF_W-1:0]        a_mag, b_mag;
  logic                               ab_neg;

  // accumulators
  logic signed [vdnc_pkg::SUM_W-1:0] sum_acc;
  logic signed [vdnc_pkg::ACC_W-1:0] dot_acc;
  logic [vdnc_pkg::ACC_W-1:0]        square_a_acc, square_b_acc;
  logic [vdnc_pkg::CNT_W-1:0]        pair_count;
  logic                              overflow_seen;
  logic [vdnc_pkg::ACC_W-1:0]        dot_mag;

  // shared multiplier
  logic [vdnc_pkg::HALF_W-1:0] mul_x, mul_y;
  logic [vdnc_pkg::ACC_W-1:0]  mul_reg;
  logic [1:0]                  pp_sel;
  logic [vdnc_pkg::WIDE_W-1:0] pp_ext, pp_term;

  // wide products and divider
  logic [vdnc_pkg::WIDE_W-1:0] num, den, rem, rem_sub;
  logic [vdnc_pkg::QUO_W-1:0]  quo, quo_next;
  logic                        div_ge;

  // square root unit
  logic [vdnc_pkg::ACC_W-1:0] sq_v, sq_root, sq_bit;
  logic [vdnc_pkg::ACC_W-1:0] sq_sum, sq_v_n, sq_root_n, sq_init;
  logic                       sq_ge;

  // results
  logic [vdnc_pkg::NORM_W-1:0]       norm_a, norm_b;
  logic signed [vdnc_pkg::COS_W-1:0] cos_reg;
  logic [vdnc_pkg::COS_W-1:0]        cos_q;
  logic                              zero_reg;

  assign s_tready = (state == vdnc_pkg::ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  assign a_abs  = a_reg[vdnc_pkg::ELEM_W-1] ? -{a_reg[vdnc_pkg::ELEM_W-1], a_reg}
                                            :  {a_reg[vdnc_pkg::ELEM_W-1], a_reg};
  assign b_abs  = b_reg[vdnc_pkg::ELEM_W-1] ? -{b_reg[vdnc_pkg::ELEM_W-1], b_reg}
                                            :  {b_reg[vdnc_pkg::ELEM_W-1], b_reg};
  assign a_mag  = vdnc_pkg::HALF_W'($unsigned(a_abs));
  assign b_mag  = vdnc_pkg::HALF_W'($unsigned(b_abs));
  assign ab_neg = a_reg[vdnc_pkg::ELEM_W-1] ^ b_reg[vdnc_pkg::ELEM_W-1];

  assign dot_mag = dot_acc[vdnc_pkg::ACC_W-1] ? $unsigned(-dot_acc) : $unsigned(dot_acc);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdnc_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    sq_load    = 1'b0;
    sq_src     = vdnc_pkg::SQ_SRC_A;
    out_load   = 1'b0;
    unique case (state)
      vdnc_pkg::ST_IDLE: begin
        if (accept) begin
          if (pair_count < vdnc_pkg::MAX_COUNT) begin
            state_next = vdnc_pkg::ST_AB;
          end else if (s_tlast) begin
            state_next = vdnc_pkg::ST_SQRT_A;
            sq_load    = 1'b1;
          end
        end
      end
      vdnc_pkg::ST_AB: state_next = vdnc_pkg::ST_AA;
      vdnc_pkg::ST_AA: state_next = vdnc_pkg::ST_BB;
      vdnc_pkg::ST_BB: state_next = vdnc_pkg::ST_BB_ADD;
      vdnc_pkg::ST_BB_ADD: begin
        if (last_reg) begin
          state_next = vdnc_pkg::ST_SQRT_A;
          sq_load    = 1'b1;
        end else begin
          state_next = vdnc_pkg::ST_IDLE;
        end
      end
      vdnc_pkg::ST_SQRT_A: begin
        if (step == vdnc_pkg::SQRT_LAST) begin
          state_next = vdnc_pkg::ST_SQRT_B;
          sq_load    = 1'b1;
          sq_src     = vdnc_pkg::SQ_SRC_B;
        end
      end
      vdnc_pkg::ST_SQRT_B: begin
        if (step == vdnc_pkg::SQRT_LAST) begin
          if (square_a_acc == '0 || square_b_acc == '0) begin
            state_next = vdnc_pkg::ST_FINISH;
          end else begin
            state_next = vdnc_pkg::ST_MUL_D;
          end
        end
      end
      vdnc_pkg::ST_MUL_D: begin
        if (step == vdnc_pkg::PP_LAST) state_next = vdnc_pkg::ST_MUL_P;
      end
      vdnc_pkg::ST_MUL_P: begin
        if (step == vdnc_pkg::PP_LAST) state_next = vdnc_pkg::ST_DIV;
      end
      vdnc_pkg::ST_DIV: begin
        if (step == vdnc_pkg::DIV_LAST) begin
          state_next = vdnc_pkg::ST_SQRT_Q;
          sq_load    = 1'b1;
          sq_src     = vdnc_pkg::SQ_SRC_Q;
        end
      end
      vdnc_pkg::ST_SQRT_Q: begin
        if (step == vdnc_pkg::SQRT_LAST) state_next = vdnc_pkg::ST_FINISH;
      end
      vdnc_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = vdnc_pkg::ST_IDLE;
        end
      end
      default: state_next = vdnc_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- shared multiplier
  always_comb begin
    unique case (state)
      vdnc_pkg::ST_AB: begin
        mul_x = a_mag;
        mul_y = b_mag;
      end
      vdnc_pkg::ST_AA: begin
        mul_x = a_mag;
        mul_y = a_mag;
      end
      vdnc_pkg::ST_BB: begin
        mul_x = b_mag;
        mul_y = b_mag;
      end
      vdnc_pkg::ST_MUL_D: begin
        mul_x = step[1] ? dot_mag[vdnc_pkg::ACC_W-1:vdnc_pkg::HALF_W]
                        : dot_mag[vdnc_pkg::HALF_W-1:0];
        mul_y = step[0] ? dot_mag[vdnc_pkg::ACC_W-1:vdnc_pkg::HALF_W]
                        : dot_mag[vdnc_pkg::HALF_W-1:0];
      end
      vdnc_pkg::ST_MUL_P: begin
        mul_x = step[1] ? square_a_acc[vdnc_pkg::ACC_W-1:vdnc_pkg::HALF_W]
                        : square_a_acc[vdnc_pkg::HALF_W-1:0];
        mul_y = step[0] ? square_b_acc[vdnc_pkg::ACC_W-1:vdnc_pkg::HALF_W]
                        : square_b_acc[vdnc_pkg::HALF_W-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_reg <= mul_x * mul_y;
    pp_sel  <= step[1:0];
  end

  // weight the partial product issued last cycle by its half positions
  assign pp_ext = vdnc_pkg::WIDE_W'(mul_reg);
  always_comb begin
    unique case (pp_sel)
      2'b00:        pp_term = pp_ext;
      2'b01, 2'b10: pp_term = pp_ext << vdnc_pkg::HALF_W;
      default:      pp_term = pp_ext << (2 * vdnc_pkg::HALF_W);
    endcase
  end

  // ----------------------------------------------------------------- divider
  assign div_ge   = (rem >= den);
  assign rem_sub  = div_ge ? rem - den : rem;
  assign quo_next = {quo[vdnc_pkg::QUO_W-2:0], div_ge};

  // ------------------------------------------------------------- square root
  assign sq_sum    = sq_root + sq_bit;
  assign sq_ge     = (sq_v >= sq_sum);
  assign sq_v_n    = sq_ge ? sq_v - sq_sum : sq_v;
  assign sq_root_n = sq_ge ? (sq_root >> 1) + sq_bit : sq_root >> 1;

  always_comb begin
    unique case (sq_src)
      vdnc_pkg::SQ_SRC_A: sq_init = square_a_acc;
      vdnc_pkg::SQ_SRC_B: sq_init = square_b_acc;
      default:            sq_init = vdnc_pkg::ACC_W'(quo_next);
    endcase
  end

  // truncated magnitude of the cosine, at most one in Q1.15
  assign cos_q = sq_root_n[vdnc_pkg::COS_W-1:0];

  always_ff @(posedge clk) begin
    if (sq_load) begin
      sq_v    <= sq_init;
      sq_root <= '0;
      sq_bit  <= vdnc_pkg::ACC_W'(1) << (vdnc_pkg::ACC_W - 2);
    end else begin
      sq_v    <= sq_v_n;
      sq_root <= sq_root_n;
      sq_bit  <= sq_bit >> 2;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      dot_acc       <= '0;
      square_a_acc  <= '0;
      square_b_acc  <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        vdnc_pkg::ST_IDLE: begin
          if (accept) begin
            a_reg    <= s_tdata[vdnc_pkg::ELEM_W-1:0];
            b_reg    <= s_tdata[2*vdnc_pkg::ELEM_W-1:vdnc_pkg::ELEM_W];
            last_reg <= s_tlast;
            if (pair_count == vdnc_pkg::MAX_COUNT) overflow_seen <= 1'b1;
          end
        end
        vdnc_pkg::ST_AA: begin
          dot_acc    <= ab_neg ? dot_acc - $signed(mul_reg) : dot_acc + $signed(mul_reg);
          sum_acc    <= sum_acc + vdnc_pkg::SUM_W'(a_reg);
          pair_count <= pair_count + 1'b1;
        end
        vdnc_pkg::ST_BB:     square_a_acc <= square_a_acc + mul_reg;
        vdnc_pkg::ST_BB_ADD: square_b_acc <= square_b_acc + mul_reg;
        vdnc_pkg::ST_SQRT_A: begin
          if (step == vdnc_pkg::SQRT_LAST) norm_a <= sq_root_n[vdnc_pkg::NORM_W-1:0];
        end
        vdnc_pkg::ST_SQRT_B: begin
          if (step == vdnc_pkg::SQRT_LAST) begin
            norm_b   <= sq_root_n[vdnc_pkg::NORM_W-1:0];
            zero_reg <= (square_a_acc == '0) || (square_b_acc == '0);
            cos_reg  <= '0;
          end
        end
        vdnc_pkg::ST_MUL_D: begin
          num <= (step == '0) ? '0 : num + pp_term;
        end
        vdnc_pkg::ST_MUL_P: begin
          den <= (step == '0) ? '0 : den + pp_term;
          // dot^2 is complete; start the division of dot^2 * 2^30 by sqa*sqb
          rem <= num;
          quo <= '0;
        end
        vdnc_pkg::ST_DIV: begin
          rem <= {rem_sub[vdnc_pkg::WIDE_W-2:0], 1'b0};
          quo <= quo_next;
        end
        vdnc_pkg::ST_SQRT_Q: begin
          if (step == vdnc_pkg::SQRT_LAST) begin
            if (dot_acc[vdnc_pkg::ACC_W-1]) begin
              cos_reg <= -$signed(cos_q);
            end else begin
              cos_reg <= cos_q[vdnc_pkg::COS_W-1] ? {1'b0, {(vdnc_pkg::COS_W-1){1'b1}}}
                                                  : $signed(cos_q);
            end
          end
        end
        vdnc_pkg::ST_FINISH: begin
          if (out_load) begin
            sum_acc       <= '0;
            dot_acc       <= '0;
            square_a_acc  <= '0;
            square_b_acc  <= '0;
            pair_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------ output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, pair_count, cos_reg, norm_b, norm_a, dot_acc, sum_acc};
      m_tuser <= {overflow_seen, zero_reg};
    end
  end

  // -------------------------------------------------------------- assertions
  `VDNC_ASSERT_NEXT(a_overflow_mark,
    accept && pair_count == vdnc_pkg::MAX_COUNT, overflow_seen,
    "pair past the length limit did not set overflow")
  `VDNC_ASSERT_NOW(a_div_range, state == vdnc_pkg::ST_DIV, (rem >> 1) < den,
    "division remainder out of range")
  `VDNC_ASSERT_NOW(a_zero_cosine, m_tvalid && m_tuser[0], m_tdata[131:116] == 16'h0000,
    "zero norm word carries a nonzero cosine")

endmodule
